// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top-level RTL file of the safety check engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BSC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("safety check assertion failed");

// Next-cycle implication, checked outside reset.
`define BSC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("safety check assertion failed");

`endif

// ===== rtl/bsc_pkg.sv =====
// Types and constants of the banker's safety check engine.
`default_nettype none

package bsc_pkg;

    // Field widths
    localparam int AMT_W   = 16;
    localparam int HELD_W  = 17;
    localparam int AVAIL_W = 18;

    // Allocation and availability limits
    localparam int HELD_MAX  = 131071;
    localparam int AVAIL_MIN = -131072;

    // Input item kinds
    localparam logic [1:0] KIND_LOAD_TOTAL = 2'd0;
    localparam logic [1:0] KIND_LOAD_CLAIM = 2'd1;
    localparam logic [1:0] KIND_REQUEST    = 2'd2;

    // Configuration register indexes
    localparam logic [0:0] CFG_PROCESS_COUNT  = 1'd0;
    localparam logic [0:0] CFG_RESOURCE_COUNT = 1'd1;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PRE,
        ST_PRE_END,
        ST_ROW,
        ST_SWEEP,
        ST_FIT,
        ST_NEXT,
        ST_FINAL,
        ST_COMMIT
    } bsc_state_t;

endpackage

`default_nettype wire

// ===== rtl/bsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bsc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write one entry, read one entry a cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/bankers_safety_check_top.sv =====
// Banker's algorithm grant engine: loads, request gathering and safety sweep.
//
//  channel   signals                                      handshake
//  -------   -------------------------------------------  --------------------------
//  config    cfg_index, cfg_data                          cfg_we, no wait
//  input     kind, process, resource, amount, last        start && !busy
//  result    accepted                                     done, one cycle, no stall
//
// After reset both memories are swept to zero, one entry a cycle, over all
// MAX_PROCS * 2**ceil(log2(MAX_RES)) entries (128 at the defaults); busy stays high.
// Loads and request elements without last never raise busy.
// A request with last runs on the claim and allocation memory read port, one
// resource per cycle: a precheck of the requesting row, then sweeps over the n
// rows (a retired row is skipped), up to n+1 sweeps, then the commit (n the active count).
// done pulses for one cycle with the verdict; the receiver cannot stall it.
`default_nettype none
`include "assert_macros.svh"

module bankers_safety_check_top
    import bsc_pkg::*;
#(
    parameter int MAX_PROCS = 16,
    parameter int MAX_RES   = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [4:0]  cfg_data,
    input  wire logic        start,
    input  wire logic [1:0]  kind,
    input  wire logic [3:0]  process,
    input  wire logic [2:0]  resource,
    input  wire logic [15:0] amount,
    input  wire logic        last,
    output logic             busy,
    output logic             done,
    output logic             accepted
);

    localparam int PROC_AW = $clog2(MAX_PROCS);
    localparam int RES_AW  = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int ADDR_W  = PROC_AW + RES_AW;
    localparam int DEPTH   = MAX_PROCS * (2 ** RES_AW);
    localparam int TAV_W   = 19 + PROC_AW;

    // Configuration
    logic [4:0] process_count_reg;
    logic [3:0] resource_count_reg;

    // Sequencer control
    bsc_state_t          state_reg, state_next;
    logic [RES_AW-1:0]   res_cnt_reg, res_cnt_next;
    logic                issue_done_reg, issue_done_next;
    logic                rd_vld_reg, rd_vld_next;
    logic [RES_AW-1:0]   rd_res_reg, rd_res_next;
    logic                rd_last_reg, rd_last_next;
    logic [PROC_AW-1:0]  proc_cnt_reg, proc_cnt_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic                ovf_reg, ovf_next;
    logic                fit_reg, fit_next;
    logic                nz_reg, nz_next;
    logic                changed_reg, changed_next;
    logic [MAX_PROCS-1:0] retired_reg, retired_next;
    logic                done_reg, done_next;
    logic                accepted_reg, accepted_next;
    logic                req_clr;
    logic                held_we;

    // Architectural and working state
    logic signed [AVAIL_W-1:0] avail_reg   [MAX_RES];
    logic        [AMT_W-1:0]   req_reg     [MAX_RES];
    logic        [3:0]         pproc_reg;
    logic        [HELD_W-1:0]  prow_reg    [MAX_RES];
    logic        [HELD_W-1:0]  rowbuf_reg  [MAX_RES];
    logic signed [TAV_W-1:0]   t_avail_reg [MAX_RES];

    // Derived values
    logic                      in_acc;
    logic                      res_ok;
    logic                      proc_ok;
    logic [RES_AW-1:0]         res_idx;
    logic [PROC_AW-1:0]        n_last;
    logic [RES_AW-1:0]         m_last;
    logic                      req_p_ok;
    logic [PROC_AW-1:0]        p_addr;
    logic [RES_AW-1:0]         prow_idx;
    logic [AMT_W-1:0]          claim_rdata;
    logic [HELD_W-1:0]         held_rdata;
    logic                      claim_we;
    logic [ADDR_W-1:0]         claim_waddr;
    logic [ADDR_W-1:0]         held_waddr;
    logic [HELD_W-1:0]         held_wdata;
    logic [ADDR_W-1:0]         mem_raddr;
    logic [AVAIL_W:0]          hsum;
    logic signed [AVAIL_W:0]   nav;
    logic                      elem_ovf;
    logic [HELD_W-1:0]         th;
    logic signed [TAV_W-1:0]   need_w;
    logic                      elem_over;
    logic                      all_ok;

    assign busy     = (state_reg != ST_IDLE);
    assign done     = done_reg;
    assign accepted = accepted_reg;
    assign in_acc   = start && !busy;
    assign res_ok   = (int'(resource) < MAX_RES);
    assign proc_ok  = (int'(process) < MAX_PROCS);
    assign res_idx  = RES_AW'(resource);
    assign p_addr   = PROC_AW'(pproc_reg);

    // Clamp the active counts to their legal ranges
    always_comb
    begin
        if (process_count_reg == 5'd0)
        begin
            n_last = '0;
        end
        else if (int'(process_count_reg) > MAX_PROCS)
        begin
            n_last = PROC_AW'(MAX_PROCS - 1);
        end
        else
        begin
            n_last = PROC_AW'(process_count_reg - 5'd1);
        end

        if (resource_count_reg == 4'd0)
        begin
            m_last = '0;
        end
        else if (int'(resource_count_reg) > MAX_RES)
        begin
            m_last = RES_AW'(MAX_RES - 1);
        end
        else
        begin
            m_last = RES_AW'(resource_count_reg - 4'd1);
        end
    end

    assign req_p_ok = (int'(process) <= int'(n_last));

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            process_count_reg  <= 5'd16;
            resource_count_reg <= 4'd8;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PROCESS_COUNT:  process_count_reg  <= cfg_data;
                CFG_RESOURCE_COUNT: resource_count_reg <= cfg_data[3:0];
            endcase
        end
    end

    // Claim and allocation memories
    assign claim_we    = (state_reg == ST_CLEAR) ||
                         (in_acc && kind == KIND_LOAD_CLAIM && res_ok && proc_ok);
    assign claim_waddr = (state_reg == ST_CLEAR) ? clr_addr_reg
                                                 : {PROC_AW'(process), res_idx};
    assign held_waddr  = (state_reg == ST_CLEAR) ? clr_addr_reg : {p_addr, res_cnt_reg};
    assign held_wdata  = (state_reg == ST_CLEAR) ? '0 : prow_reg[prow_idx];
    assign mem_raddr   = {proc_cnt_reg, res_cnt_reg};

    bsc_ram #(
        .WIDTH (AMT_W),
        .DEPTH (DEPTH)
    ) u_claim_ram (
        .clk   (clk),
        .we    (claim_we),
        .waddr (claim_waddr),
        .wdata ((state_reg == ST_CLEAR) ? '0 : amount),
        .raddr (mem_raddr),
        .rdata (claim_rdata)
    );

    bsc_ram #(
        .WIDTH (HELD_W),
        .DEPTH (DEPTH)
    ) u_held_ram (
        .clk   (clk),
        .we    (held_we),
        .waddr (held_waddr),
        .wdata (held_wdata),
        .raddr (mem_raddr),
        .rdata (held_rdata)
    );

    // Per-resource arithmetic on the beat coming back from memory
    assign prow_idx  = (state_reg == ST_COMMIT) ? res_cnt_reg : rd_res_reg;
    assign hsum      = {2'b00, held_rdata} + {3'b000, req_reg[rd_res_reg]};
    assign nav       = {avail_reg[rd_res_reg][AVAIL_W-1], avail_reg[rd_res_reg]}
                       - {3'b000, req_reg[rd_res_reg]};
    assign elem_ovf  = (hsum > (AVAIL_W+1)'(HELD_MAX)) || (nav < (AVAIL_W+1)'(AVAIL_MIN));
    assign th        = (proc_cnt_reg == p_addr) ? prow_reg[prow_idx] : held_rdata;
    assign need_w    = {{(TAV_W-AMT_W){1'b0}}, claim_rdata}
                       - {{(TAV_W-HELD_W){1'b0}}, th};
    assign elem_over = (need_w > t_avail_reg[rd_res_reg]);

    // Every active process retired or never holding anything
    always_comb
    begin
        all_ok = 1'b1;
        for (int i = 0; i < MAX_PROCS; i++)
        begin
            if (i <= int'(n_last) && !retired_reg[i])
            begin
                all_ok = 1'b0;
            end
        end
    end

    // Sequencer state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            res_cnt_reg    <= '0;
            issue_done_reg <= 1'b0;
            rd_vld_reg     <= 1'b0;
            rd_res_reg     <= '0;
            rd_last_reg    <= 1'b0;
            proc_cnt_reg   <= '0;
            clr_addr_reg   <= '0;
            ovf_reg        <= 1'b0;
            fit_reg        <= 1'b0;
            nz_reg         <= 1'b0;
            changed_reg    <= 1'b0;
            retired_reg    <= '0;
            done_reg       <= 1'b0;
            accepted_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            res_cnt_reg    <= res_cnt_next;
            issue_done_reg <= issue_done_next;
            rd_vld_reg     <= rd_vld_next;
            rd_res_reg     <= rd_res_next;
            rd_last_reg    <= rd_last_next;
            proc_cnt_reg   <= proc_cnt_next;
            clr_addr_reg   <= clr_addr_next;
            ovf_reg        <= ovf_next;
            fit_reg        <= fit_next;
            nz_reg         <= nz_next;
            changed_reg    <= changed_next;
            retired_reg    <= retired_next;
            done_reg       <= done_next;
            accepted_reg   <= accepted_next;
        end
    end

    // Sequencer next state and control
    always_comb
    begin
        state_next      = state_reg;
        res_cnt_next    = res_cnt_reg;
        issue_done_next = issue_done_reg;
        rd_vld_next     = 1'b0;
        rd_res_next     = rd_res_reg;
        rd_last_next    = rd_last_reg;
        proc_cnt_next   = proc_cnt_reg;
        clr_addr_next   = clr_addr_reg;
        ovf_next        = ovf_reg;
        fit_next        = fit_reg;
        nz_next         = nz_reg;
        changed_next    = changed_reg;
        retired_next    = retired_reg;
        done_next       = 1'b0;
        accepted_next   = accepted_reg;
        req_clr         = 1'b0;
        held_we         = 1'b0;

        // Issue one row element read a cycle while scanning
        if ((state_reg == ST_PRE || state_reg == ST_SWEEP) && !issue_done_reg)
        begin
            rd_vld_next  = 1'b1;
            rd_res_next  = res_cnt_reg;
            rd_last_next = (res_cnt_reg == m_last);
            if (res_cnt_reg == m_last)
            begin
                issue_done_next = 1'b1;
            end
            else
            begin
                res_cnt_next = res_cnt_reg + 1'b1;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                held_we       = 1'b1;
                clr_addr_next = clr_addr_reg + 1'b1;
                if (clr_addr_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (in_acc && kind == KIND_REQUEST && last)
                begin
                    if (req_p_ok)
                    begin
                        state_next      = ST_PRE;
                        proc_cnt_next   = PROC_AW'(process);
                        res_cnt_next    = '0;
                        issue_done_next = 1'b0;
                        ovf_next        = 1'b0;
                    end
                    else
                    begin
                        done_next     = 1'b1;
                        accepted_next = 1'b0;
                        req_clr       = 1'b1;
                    end
                end
            end

            ST_PRE:
            begin
                if (rd_vld_reg)
                begin
                    ovf_next = ovf_reg | elem_ovf;
                    if (rd_last_reg)
                    begin
                        state_next = ST_PRE_END;
                    end
                end
            end

            ST_PRE_END:
            begin
                if (ovf_reg)
                begin
                    done_next     = 1'b1;
                    accepted_next = 1'b0;
                    req_clr       = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    proc_cnt_next = '0;
                    changed_next  = 1'b0;
                    retired_next  = '0;
                    state_next    = ST_ROW;
                end
            end

            ST_ROW:
            begin
                if (retired_reg[proc_cnt_reg])
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    res_cnt_next    = '0;
                    issue_done_next = 1'b0;
                    fit_next        = 1'b1;
                    nz_next         = 1'b0;
                    state_next      = ST_SWEEP;
                end
            end

            ST_SWEEP:
            begin
                if (rd_vld_reg)
                begin
                    fit_next = fit_reg & !elem_over;
                    nz_next  = nz_reg | (th != '0);
                    if (rd_last_reg)
                    begin
                        state_next = ST_FIT;
                    end
                end
            end

            ST_FIT:
            begin
                // Retire a fitting row, or mark an empty one as settled
                if (!nz_reg || fit_reg)
                begin
                    retired_next[proc_cnt_reg] = 1'b1;
                end
                if (nz_reg && fit_reg)
                begin
                    changed_next = 1'b1;
                end
                state_next = ST_NEXT;
            end

            ST_NEXT:
            begin
                if (proc_cnt_reg == n_last)
                begin
                    if (changed_reg)
                    begin
                        proc_cnt_next = '0;
                        changed_next  = 1'b0;
                        state_next    = ST_ROW;
                    end
                    else
                    begin
                        state_next = ST_FINAL;
                    end
                end
                else
                begin
                    proc_cnt_next = proc_cnt_reg + 1'b1;
                    state_next    = ST_ROW;
                end
            end

            ST_FINAL:
            begin
                if (all_ok)
                begin
                    res_cnt_next = '0;
                    state_next   = ST_COMMIT;
                end
                else
                begin
                    done_next     = 1'b1;
                    accepted_next = 1'b0;
                    req_clr       = 1'b1;
                    state_next    = ST_IDLE;
                end
            end

            ST_COMMIT:
            begin
                held_we = 1'b1;
                if (res_cnt_reg == m_last)
                begin
                    done_next     = 1'b1;
                    accepted_next = 1'b1;
                    req_clr       = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    res_cnt_next = res_cnt_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Availability, gathered request and requesting process
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avail_reg <= '{default: '0};
            req_reg   <= '{default: '0};
            pproc_reg <= '0;
        end
        else
        begin
            // Load a resource total
            if (in_acc && kind == KIND_LOAD_TOTAL && res_ok)
            begin
                avail_reg[res_idx] <= {2'b00, amount};
            end

            // Keep the trial availability of an accepted request
            if (state_reg == ST_FINAL && all_ok)
            begin
                for (int r = 0; r < MAX_RES; r++)
                begin
                    if (r <= int'(m_last))
                    begin
                        avail_reg[r] <= avail_reg[r] - {2'b00, req_reg[r]};
                    end
                end
            end

            // Gather request beats, drop them after each verdict
            if (req_clr)
            begin
                req_reg <= '{default: '0};
            end
            else if (in_acc && kind == KIND_REQUEST && res_ok)
            begin
                req_reg[res_idx] <= amount;
            end

            if (in_acc && kind == KIND_REQUEST)
            begin
                pproc_reg <= process;
            end
        end
    end

    // Trial row, row buffer and trial availability
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PRE && rd_vld_reg)
        begin
            prow_reg[rd_res_reg]    <= hsum[HELD_W-1:0];
            t_avail_reg[rd_res_reg] <= TAV_W'(nav);
        end

        if (state_reg == ST_SWEEP && rd_vld_reg)
        begin
            rowbuf_reg[rd_res_reg] <= th;
        end

        // Return a retired row's allocation
        if (state_reg == ST_FIT && nz_reg && fit_reg)
        begin
            for (int r = 0; r < MAX_RES; r++)
            begin
                if (r <= int'(m_last))
                begin
                    t_avail_reg[r] <= t_avail_reg[r]
                                      + {{(TAV_W-HELD_W){1'b0}}, rowbuf_reg[r]};
                end
            end
        end
    end

    // Allocation memory is written only by the clear sweep and the commit
    `BSC_ASSERT_IMP(a_held_write_window, held_we, state_reg == ST_COMMIT || state_reg == ST_CLEAR)

    // A granted verdict always follows the commit of the trial row
    `BSC_ASSERT_IMP(a_grant_after_commit, done_reg && accepted_reg, $past(state_reg) == ST_COMMIT)

    // No commit after an overflowing precheck
    `BSC_ASSERT_IMP(a_commit_no_ovf, state_reg == ST_COMMIT, !ovf_reg)

endmodule

`default_nettype wire
